[src/piecewise_cubic_evaluator_macros.svh]
// Assertion macros for the piecewise cubic evaluator.
// Included by the top level; no other dependencies.
`ifndef PIECEWISE_CUBIC_EVALUATOR_MACROS_SVH
`define PIECEWISE_CUBIC_EVALUATOR_MACROS_SVH

`ifndef SYNTHESIS
`define PCE_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PCE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PCE_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define PCE_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

[src/pce_pkg.sv]
// Shared constants, codes and types of the piecewise cubic evaluator.
// No dependencies.
package pce_pkg;

   localparam int SEGMENTS    = 64;
   localparam int FRAC_BITS   = 16;

   localparam int DATA_W      = 32;
   localparam int IDX_W       = 7;
   localparam int SEL_W       = 2;
   localparam int TYPE_W      = 2;
   localparam int CSR_W       = 7;
   localparam int SEG_W       = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int BRK_DEPTH   = SEGMENTS + 1;
   localparam int BRK_AW      = $clog2(BRK_DEPTH);
   localparam int COEF_DEPTH  = 4 * SEGMENTS;
   localparam int COEF_AW     = SEG_W + SEL_W;
   localparam int DX_W        = DATA_W + 1;
   localparam int PROD_W      = DATA_W + DX_W;
   localparam int RND_W       = PROD_W - FRAC_BITS;
   localparam int SUM_W       = RND_W + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_W-1:0] SEGS_RESET = CSR_W'(SEGMENTS);

   localparam logic [TYPE_W-1:0] REQ_BRK  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_COEF = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_EVAL = 2'd2;

   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [DATA_W-1:0] VAL_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] VAL_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_BRK,
      OP_COEF,
      OP_EVAL
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [BRK_AW-1:0]         brk_addr;
      logic [COEF_AW-1:0]        coef_addr;
      logic [DATA_W-1:0]         data;
   } q_entry_type;

   typedef struct packed {
      logic                      valid;
      q_entry_type               entry;
   } q_word_type;

   typedef struct packed {
      logic                      busy;
      logic                      pop;
   } back_status_type;

endpackage

[src/piecewise_cubic_evaluator.sv]
// Piecewise cubic evaluator: accepts load and evaluate requests, returns Q16.16 values.
// Top level; depends on pce_pkg, pce_front, pce_queue, pce_back and the macros header.
//
// Usage:
//   req_*  : one word per request: break write, coefficient write or evaluate.
//            Load words and unused codes give no response word.
//   rsp_*  : one word per evaluate request, in request order: value, segment, clamp flag.
//   csr_*  : segments_in_use, write only while the block is idle. Always ready.
// Operation:
//   A load word is written to its store as the idle back end pops it. An evaluate
//   word scans the breaks one per cycle through the break store read port, then
//   runs three Horner steps (multiply, round, add and clamp) on the one multiplier.
//   One evaluation is in the back end at a time; the front end keeps taking words
//   into a two-word queue meanwhile.
// Reset: synchronous; queue and result register empty, segments_in_use = 64.
//   Break and coefficient stores are not cleared; write them before use.
// Stall: a held response waits in the output register; the back end then stops
//   in its last state and the queue fills, after which req_ready falls.
`include "piecewise_cubic_evaluator_macros.svh"

module piecewise_cubic_evaluator import pce_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [TYPE_W-1:0]   req_type,
   input  logic [IDX_W-1:0]    req_entry_index,
   input  logic [SEL_W-1:0]    req_coeff_sel,
   input  logic [DATA_W-1:0]   req_load_value,
   input  logic [DATA_W-1:0]   req_point_x,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DATA_W-1:0]   rsp_spline_value,
   output logic [SEG_W-1:0]    rsp_segment_used,
   output logic                rsp_saturated,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_W-1:0]    csr_segments_in_use
);

   q_word_type        q_push;
   q_word_type        q_head;
   logic              q_full;
   logic [BRK_AW-1:0] segs;
   back_status_type   bk_status;

   pce_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .entry_index         (req_entry_index),
      .coeff_sel           (req_coeff_sel),
      .load_value          (req_load_value),
      .point_x             (req_point_x),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_segments_in_use (csr_segments_in_use),
      .q_full              (q_full),
      .push                (q_push),
      .segs                (segs)
   );

   pce_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .pop   (bk_status.pop),
      .head  (q_head),
      .full  (q_full)
   );

   pce_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (q_head),
      .segs         (segs),
      .status       (bk_status),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .spline_value (rsp_spline_value),
      .segment_used (rsp_segment_used),
      .saturated    (rsp_saturated)
   );

   `PCE_ASSERT_IMPL(a_pop_has_word, clock, reset, bk_status.pop, q_head.valid, "pop from empty queue")
   `PCE_ASSERT_NEXT(a_push_lands, clock, reset, q_push.valid && !q_head.valid, q_head.valid, "pushed word lost")
   `PCE_ASSERT_IMPL(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(bk_status.busy), "response without evaluation")

endmodule

[src/pce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/pce_front.sv]
// Front end: request and register acceptance, request classification.
// Depends on pce_pkg.
module pce_front import pce_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [TYPE_W-1:0]   req_type,
   input  logic [IDX_W-1:0]    entry_index,
   input  logic [SEL_W-1:0]    coeff_sel,
   input  logic [DATA_W-1:0]   load_value,
   input  logic [DATA_W-1:0]   point_x,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_W-1:0]    csr_segments_in_use,
   input  logic                q_full,
   output q_word_type          push,
   output logic [BRK_AW-1:0]   segs
);

   logic [CSR_W-1:0] segs_ff;
   logic [CSR_W-1:0] segs_in;
   logic             keep;
   op_type           op;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;

   always_comb begin
      segs_in = segs_ff;
      if (csr_valid) begin
         segs_in = csr_segments_in_use;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         segs_ff <= SEGS_RESET;
      end else begin
         segs_ff <= segs_in;
      end
   end

   always_comb begin
      priority if (segs_ff == '0) begin
         segs = BRK_AW'(1);
      end else if (int'(segs_ff) > SEGMENTS) begin
         segs = BRK_AW'(SEGMENTS);
      end else begin
         segs = BRK_AW'(segs_ff);
      end
   end

   always_comb begin
      keep = 1'b0;
      op   = OP_EVAL;
      unique case (req_type)
         REQ_BRK: begin
            op   = OP_BRK;
            keep = int'(entry_index) <= SEGMENTS;
         end
         REQ_COEF: begin
            op   = OP_COEF;
            keep = int'(entry_index) < SEGMENTS;
         end
         REQ_EVAL: begin
            op   = OP_EVAL;
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   always_comb begin
      push.valid           = req_valid && req_ready && keep;
      push.entry.op        = op;
      push.entry.brk_addr  = BRK_AW'(entry_index);
      push.entry.coef_addr = {SEG_W'(entry_index), coeff_sel};
      push.entry.data      = (op == OP_EVAL) ? point_x : load_value;
   end

endmodule

[src/pce_queue.sv]
// Short word queue between the front and back ends.
// Depends on pce_pkg.
module pce_queue import pce_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  q_word_type      push,
   input  logic            pop,
   output q_word_type      head,
   output logic            full
);

   q_entry_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign do_push    = push.valid && !full;
   assign head.valid = count_ff != '0;
   assign head.entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

[src/pce_back.sv]
// Back end: break and coefficient stores, interval scan, Horner sequencer
// and result register. Depends on pce_pkg and pce_ram.
module pce_back import pce_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  q_word_type          head,
   input  logic [BRK_AW-1:0]   segs,
   output back_status_type     status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DATA_W-1:0]   spline_value,
   output logic [SEG_W-1:0]    segment_used,
   output logic                saturated
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SCAN   = 8'b0000_0010,
      ST_FETCH  = 8'b0000_0100,
      ST_LOADA  = 8'b0000_1000,
      ST_MUL    = 8'b0001_0000,
      ST_RND    = 8'b0010_0000,
      ST_ACC    = 8'b0100_0000,
      ST_RESULT = 8'b1000_0000
   } state_type;

   state_type                 state_ff, state_in;
   logic signed [DATA_W-1:0]  x_ff, x_in;
   logic [BRK_AW-1:0]         segs_ff, segs_in;
   logic [BRK_AW-1:0]         idx_ff, idx_in;
   logic [BRK_AW-1:0]         rd_idx_ff, rd_idx_in;
   logic                      rdv_ff, rdv_in;
   logic [SEG_W-1:0]          seg_ff, seg_in;
   logic [SEL_W-1:0]          ord_ff, ord_in;
   logic signed [DX_W-1:0]    dx_ff, dx_in;
   logic signed [DATA_W-1:0]  t_ff, t_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [RND_W-1:0]   rnd_ff, rnd_in;
   logic                      sat_ff, sat_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]         rsp_value_ff, rsp_value_in;
   logic [SEG_W-1:0]          rsp_seg_ff, rsp_seg_in;
   logic                      rsp_sat_ff, rsp_sat_in;

   logic [DATA_W-1:0]         brk_rdata;
   logic [DATA_W-1:0]         coef_rdata;
   logic [BRK_AW-1:0]         brk_raddr;
   logic [COEF_AW-1:0]        coef_raddr;
   logic                      brk_we;
   logic                      coef_we;
   logic                      pop;
   logic                      stop;
   logic signed [PROD_W-1:0]  rnd_full;
   logic signed [SUM_W-1:0]   sum;
   logic [SUM_W-DATA_W:0]     upper;
   logic                      ovf;

   assign brk_we     = pop && (head.entry.op == OP_BRK);
   assign coef_we    = pop && (head.entry.op == OP_COEF);
   assign brk_raddr  = (state_ff == ST_SCAN) ? idx_ff : BRK_AW'(seg_ff);
   assign coef_raddr = {seg_ff, ord_ff};

   pce_ram #(
      .WIDTH (DATA_W),
      .DEPTH (BRK_DEPTH)
   ) u_brk_ram (
      .clock   (clock),
      .wr_en   (brk_we),
      .wr_addr (head.entry.brk_addr),
      .wr_data (head.entry.data),
      .rd_addr (brk_raddr),
      .rd_data (brk_rdata)
   );

   pce_ram #(
      .WIDTH (DATA_W),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (head.entry.coef_addr),
      .wr_data (head.entry.data),
      .rd_addr (coef_raddr),
      .rd_data (coef_rdata)
   );

   assign stop     = (x_ff <= $signed(brk_rdata)) || (rd_idx_ff == segs_ff);
   assign rnd_full = prod_ff + RND_HALF - PROD_W'(prod_ff[PROD_W-1]);
   assign sum      = SUM_W'(rnd_ff) + SUM_W'($signed(coef_rdata));
   assign upper    = sum[SUM_W-1:DATA_W-1];
   assign ovf      = !((&upper) || (~|upper));

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      segs_in      = segs_ff;
      idx_in       = idx_ff;
      rd_idx_in    = rd_idx_ff;
      rdv_in       = 1'b0;
      seg_in       = seg_ff;
      ord_in       = ord_ff;
      dx_in        = dx_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      rnd_in       = rnd_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_sat_in   = rsp_sat_ff;
      pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.entry.op == OP_EVAL) begin
                  x_in     = $signed(head.entry.data);
                  segs_in  = segs;
                  idx_in   = BRK_AW'(1);
                  sat_in   = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rdv_in    = 1'b1;
            rd_idx_in = idx_ff;
            if (idx_ff != segs_ff) begin
               idx_in = idx_ff + 1'b1;
            end
            if (rdv_ff && stop) begin
               seg_in   = SEG_W'(rd_idx_ff - 1'b1);
               ord_in   = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_LOADA;
         end
         ST_LOADA: begin
            dx_in    = DX_W'(x_ff) - DX_W'($signed(brk_rdata));
            t_in     = $signed(coef_rdata);
            ord_in   = ord_ff + 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = t_ff * dx_ff;
            state_in = ST_RND;
         end
         ST_RND: begin
            rnd_in   = rnd_full[PROD_W-1:FRAC_BITS];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            priority if (ovf) begin
               t_in = sum[SUM_W-1] ? VAL_MIN : VAL_MAX;
            end else begin
               t_in = sum[DATA_W-1:0];
            end
            sat_in = sat_ff || ovf;
            if (ord_ff == '1) begin
               state_in = ST_RESULT;
            end else begin
               ord_in   = ord_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = t_ff;
               rsp_seg_in   = seg_ff;
               rsp_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      segs_ff      <= segs_in;
      idx_ff       <= idx_in;
      rd_idx_ff    <= rd_idx_in;
      seg_ff       <= seg_in;
      ord_ff       <= ord_in;
      dx_ff        <= dx_in;
      t_ff         <= t_in;
      prod_ff      <= prod_in;
      rnd_ff       <= rnd_in;
      sat_ff       <= sat_in;
      rsp_value_ff <= rsp_value_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign status.busy  = state_ff != ST_IDLE;
   assign status.pop   = pop;
   assign rsp_valid    = rsp_valid_ff;
   assign spline_value = rsp_value_ff;
   assign segment_used = rsp_seg_ff;
   assign saturated    = rsp_sat_ff;

endmodule

[verif/pce_checker.sv]
`timescale 1ns / 1ps
// Checker for the piecewise cubic evaluator: watches the request, response and csr
// channels, predicts each evaluation and compares the response words. Uses pce_pkg.
module pce_checker import pce_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [TYPE_W-1:0]   req_type,
   input  logic [IDX_W-1:0]    req_entry_index,
   input  logic [SEL_W-1:0]    req_coeff_sel,
   input  logic [DATA_W-1:0]   req_load_value,
   input  logic [DATA_W-1:0]   req_point_x,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [DATA_W-1:0]   rsp_spline_value,
   input  logic [SEG_W-1:0]    rsp_segment_used,
   input  logic                rsp_saturated,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [CSR_W-1:0]    csr_segments_in_use,
   output int                  mismatches,
   output int                  outstanding
);

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [SEG_W-1:0]  segment;
      logic              clamped;
   } spline_result_type;

   logic signed [DATA_W-1:0] knot_table [0:SEGMENTS];
   logic signed [DATA_W-1:0] coef_table [0:4*SEGMENTS-1];
   logic [CSR_W-1:0]         segs_setting;
   spline_result_type        expected_points [$];
   spline_result_type        oldest;
   int                       errs = 0;

   // round(t*dx / 2^FRAC_BITS), ties away from zero
   function automatic longint round_product(longint t, longint dx);
      logic            neg;
      longint unsigned ut, ud, mag;
      neg = (t < 0) != (dx < 0);
      ut  = (t < 0) ? -t : t;
      ud  = (dx < 0) ? -dx : dx;
      mag = (ut * ud + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic spline_result_type predict_value(logic signed [DATA_W-1:0] x);
      int                segs, i, seg, k;
      longint            dx, t;
      logic              clamp;
      spline_result_type r;
      segs = segs_setting;
      if (segs == 0) segs = 1;
      if (segs > SEGMENTS) segs = SEGMENTS;
      i = 1;
      while (i <= segs && x > knot_table[i]) i++;
      seg = (i - 1 > segs - 1) ? segs - 1 : i - 1;
      dx    = longint'(x) - longint'(knot_table[seg]);
      t     = longint'(coef_table[4*seg]);
      clamp = 1'b0;
      for (k = 1; k < 4; k++) begin
         t = round_product(t, dx) + longint'(coef_table[4*seg + k]);
         if (t > longint'(VAL_MAX)) begin
            t     = longint'(VAL_MAX);
            clamp = 1'b1;
         end else if (t < longint'(VAL_MIN)) begin
            t     = longint'(VAL_MIN);
            clamp = 1'b1;
         end
      end
      r.value   = t[DATA_W-1:0];
      r.segment = seg[SEG_W-1:0];
      r.clamped = clamp;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_points.delete();
         segs_setting = SEGS_RESET;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $error("response word with none expected: value %0d segment %0d",
                      $signed(rsp_spline_value), rsp_segment_used);
               errs++;
            end else begin
               oldest = expected_points.pop_front();
               if (rsp_spline_value !== oldest.value) begin
                  $error("spline_value: expected %0d, got %0d",
                         $signed(oldest.value), $signed(rsp_spline_value));
                  errs++;
               end
               if (rsp_segment_used !== oldest.segment) begin
                  $error("segment_used: expected %0d, got %0d",
                         oldest.segment, rsp_segment_used);
                  errs++;
               end
               if (rsp_saturated !== oldest.clamped) begin
                  $error("saturated: expected %0d, got %0d",
                         oldest.clamped, rsp_saturated);
                  errs++;
               end
            end
         end
         if (csr_valid && csr_ready)
            segs_setting = csr_segments_in_use;
         if (req_valid && req_ready) begin
            case (req_type)
               REQ_BRK: begin
                  if (req_entry_index <= SEGMENTS)
                     knot_table[req_entry_index] = req_load_value;
               end
               REQ_COEF: begin
                  if (req_entry_index < SEGMENTS)
                     coef_table[int'(req_entry_index)*4 + int'(req_coeff_sel)] =
                        req_load_value;
               end
               REQ_EVAL: expected_points.push_back(predict_value(req_point_x));
               default: ;
            endcase
         end
      end
      outstanding <= expected_points.size();
      mismatches  <= errs;
   end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the piecewise cubic evaluator: clock, reset, request and csr
// stimulus, random response back-pressure and the verdict. Uses pce_pkg and pce_checker.
module tb import pce_pkg::*;;

   localparam logic [TYPE_W-1:0] REQ_SPARE = 2'd3;
   localparam logic [SEL_W-1:0]  SEL_CUBIC = 2'd0;
   localparam logic [SEL_W-1:0]  SEL_QUAD  = 2'd1;
   localparam logic [SEL_W-1:0]  SEL_LIN   = 2'd2;
   localparam logic [SEL_W-1:0]  SEL_CONST = 2'd3;
   localparam int DRAIN_CYCLES = 2*SEGMENTS + 64;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int PHASE_WORDS  = 198;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [TYPE_W-1:0]   req_type;
   logic [IDX_W-1:0]    req_entry_index;
   logic [SEL_W-1:0]    req_coeff_sel;
   logic [DATA_W-1:0]   req_load_value;
   logic [DATA_W-1:0]   req_point_x;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DATA_W-1:0]   rsp_spline_value;
   logic [SEG_W-1:0]    rsp_segment_used;
   logic                rsp_saturated;
   logic                csr_valid;
   logic                csr_ready;
   logic [CSR_W-1:0]    csr_segments_in_use;
   int                  mismatches, outstanding;

   int                  knot_pos [0:SEGMENTS];
   int                  active_segs = SEGMENTS;
   logic                calm = 1'b0;
   int                  words_sent = 0, points_sent = 0, settings_written = 0;
   int                  tables_loaded = 0, cycles = 0;

   piecewise_cubic_evaluator dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_entry_index     (req_entry_index),
      .req_coeff_sel       (req_coeff_sel),
      .req_load_value      (req_load_value),
      .req_point_x         (req_point_x),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_spline_value    (rsp_spline_value),
      .rsp_segment_used    (rsp_segment_used),
      .rsp_saturated       (rsp_saturated),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_segments_in_use (csr_segments_in_use)
   );

   pce_checker u_checker (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 30);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic push_word(input logic [TYPE_W-1:0] kind, input logic [IDX_W-1:0] idx,
                            input logic [SEL_W-1:0] sel, input logic [DATA_W-1:0] load,
                            input logic [DATA_W-1:0] x);
      if (!calm) begin
         while ($urandom_range(99) < 30) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_entry_index <= idx;
      req_coeff_sel   <= sel;
      req_load_value  <= load;
      req_point_x     <= x;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (kind == REQ_EVAL) points_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_setting(input int value);
      csr_valid           <= 1'b1;
      csr_segments_in_use <= CSR_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      active_segs = (value == 0) ? 1 : (value > SEGMENTS) ? SEGMENTS : value;
      settings_written++;
   endtask

   function automatic logic [DATA_W-1:0] coef_value();
      if ($urandom_range(99) < 85)
         return $signed($urandom) >>> (32 - $urandom_range(4, 20));
      return $urandom;
   endfunction

   // Ordered breaks with random spacing, then every coefficient.
   task automatic load_table();
      int k, s, q;
      knot_pos[0] = $signed($urandom) >>> 4;
      push_word(REQ_BRK, 0, SEL_CUBIC, knot_pos[0], $urandom);
      for (k = 1; k <= SEGMENTS; k++) begin
         knot_pos[k] = knot_pos[k-1] + $urandom_range(0, 1 << 20);
         push_word(REQ_BRK, IDX_W'(k), SEL_CUBIC, knot_pos[k], $urandom);
      end
      for (s = 0; s < SEGMENTS; s++)
         for (q = 0; q < 4; q++)
            push_word(REQ_COEF, IDX_W'(s), SEL_W'(q), coef_value(), $urandom);
      tables_loaded++;
   endtask

   function automatic logic [DATA_W-1:0] aim_point();
      int     mode, k;
      longint span;
      mode = $urandom_range(99);
      k    = $urandom_range(0, active_segs - 1);
      if (mode < 65) begin
         span = longint'(knot_pos[k+1]) - longint'(knot_pos[k]);
         if (span <= 0) return knot_pos[k];
         return DATA_W'(longint'(knot_pos[k]) + longint'($urandom) % (span + 1));
      end
      if (mode < 75) return knot_pos[$urandom_range(0, SEGMENTS)];
      if (mode < 83) return knot_pos[active_segs] + $urandom_range(1, 1 << 22);
      if (mode < 91) return knot_pos[0] - $urandom_range(1, 1 << 22);
      return $urandom;
   endfunction

   task automatic random_word();
      int     pick, idx;
      longint lo, hi;
      logic [DATA_W-1:0] v;
      pick = $urandom_range(99);
      if (pick < 58) begin
         push_word(REQ_EVAL, IDX_W'($urandom), SEL_W'($urandom), $urandom, aim_point());
      end else if (pick < 76) begin
         idx = ($urandom_range(99) < 90) ? $urandom_range(0, SEGMENTS - 1)
                                         : $urandom_range(SEGMENTS, 127);
         push_word(REQ_COEF, IDX_W'(idx), SEL_W'($urandom), coef_value(), $urandom);
      end else if (pick < 92) begin
         idx = ($urandom_range(99) < 85) ? $urandom_range(0, SEGMENTS)
                                         : $urandom_range(SEGMENTS + 1, 127);
         if (idx <= SEGMENTS && $urandom_range(99) < 80) begin
            lo = (idx == 0) ? longint'(knot_pos[0]) - (1 << 20) : knot_pos[idx-1];
            hi = (idx == SEGMENTS) ? longint'(knot_pos[idx]) + (1 << 20) : knot_pos[idx+1];
            v  = (hi > lo) ? DATA_W'(lo + longint'($urandom) % (hi - lo + 1)) : DATA_W'(lo);
         end else begin
            v = $urandom;
         end
         if (idx <= SEGMENTS) knot_pos[idx] = v;
         push_word(REQ_BRK, IDX_W'(idx), SEL_W'($urandom), v, $urandom);
      end else if (pick < 96) begin
         push_word(REQ_SPARE, IDX_W'($urandom), SEL_W'($urandom), $urandom, $urandom);
      end else begin
         push_word(REQ_EVAL, IDX_W'($urandom), SEL_W'($urandom), $urandom, $urandom);
      end
   endtask

   function automatic int phase_setting(int phase);
      case (phase)
         0: return 127;
         1: return 0;
         2: return SEGMENTS;
         3: return 33;
         4: return 2;
         default: return $urandom_range(1, 127);
      endcase
   endfunction

   initial begin
      int phase;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_type            <= REQ_SPARE;
      req_entry_index     <= '0;
      req_coeff_sel       <= SEL_CUBIC;
      req_load_value      <= '0;
      req_point_x         <= '0;
      csr_valid           <= 1'b0;
      csr_segments_in_use <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one segment: extremes, break hits, both extrapolations, ignored words, ties
      write_setting(1);
      push_word(REQ_BRK,  0, SEL_CUBIC, 32'hFFFF_0000, $urandom);
      push_word(REQ_BRK,  1, SEL_CUBIC, 32'h0002_0000, $urandom);
      push_word(REQ_COEF, 0, SEL_CUBIC, 32'h0001_0000, $urandom);
      push_word(REQ_COEF, 0, SEL_QUAD,  32'h8000_0000, $urandom);
      push_word(REQ_COEF, 0, SEL_LIN,   32'h0000_8000, $urandom);
      push_word(REQ_COEF, 0, SEL_CONST, 32'h7FFF_FFFF, $urandom);
      push_word(REQ_EVAL, 0, SEL_CUBIC, 32'h0, 32'h0000_0000);
      push_word(REQ_EVAL, 0, SEL_CUBIC, 32'h0, 32'hFFFF_0000);
      push_word(REQ_EVAL, 0, SEL_CUBIC, 32'h0, 32'h0002_0000);
      push_word(REQ_EVAL, 0, SEL_CUBIC, 32'h0, 32'h7FFF_FFFF);
      push_word(REQ_EVAL, 0, SEL_CUBIC, 32'h0, 32'h8000_0000);
      push_word(REQ_COEF, 64,  SEL_CONST, 32'h1234_5678, $urandom);
      push_word(REQ_COEF, 127, SEL_QUAD,  32'h1234_5678, $urandom);
      push_word(REQ_BRK,  65,  SEL_CUBIC, 32'h1234_5678, $urandom);
      push_word(REQ_BRK,  127, SEL_CUBIC, 32'h1234_5678, $urandom);
      push_word(REQ_SPARE, 0,  SEL_CUBIC, 32'h1234_5678, 32'h0000_8000);
      push_word(REQ_EVAL, 0, SEL_CUBIC, 32'h0, 32'h0000_8000);
      push_word(REQ_COEF, 0, SEL_CUBIC, 32'h0000_0001, $urandom);
      push_word(REQ_COEF, 0, SEL_QUAD,  32'h0, $urandom);
      push_word(REQ_COEF, 0, SEL_LIN,   32'h0, $urandom);
      push_word(REQ_COEF, 0, SEL_CONST, 32'h0, $urandom);
      push_word(REQ_EVAL, 0, SEL_CUBIC, 32'h0, 32'hFFFF_8000);
      push_word(REQ_EVAL, 0, SEL_CUBIC, 32'h0, 32'hFFFE_8000);
      settle();

      write_setting(SEGMENTS);
      load_table();
      for (phase = 0; phase < 6; phase++) begin
         if (phase == 3) load_table();
         settle();
         write_setting(phase_setting(phase));
         calm = (phase == 2);
         repeat (PHASE_WORDS) random_word();
      end
      settle();

      $display("Sent %0d request words, %0d of them evaluations, under %0d csr settings",
               words_sent, points_sent, settings_written);
      $display("Full tables loaded %0d times; %0d cycles run", tables_loaded, cycles);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
